### hdl/analog_stick_position_integrator_macros.svh
// Assertion macros for the stick position integrator.
// Each macro samples on the rising edge of clk_i and is disabled during reset.
`ifndef ANALOG_STICK_POSITION_INTEGRATOR_MACROS_SVH
`define ANALOG_STICK_POSITION_INTEGRATOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASPI_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication.
`define ASPI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASPI_ASSERT(lbl, pre, post, msg)
`define ASPI_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### hdl/aspi_pkg.sv
package aspi_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_SLOT = 2'd2;

  // Sensitivity code that disables the analog path
  localparam logic [1:0] SENS_OFF = 2'd3;

  // Axis modes
  localparam logic MODE_TWO_AXIS    = 1'b0;
  localparam logic MODE_SINGLE_AXIS = 1'b1;

  // Zone table selects
  localparam logic [1:0] ZTAB_COARSE = 2'd0;
  localparam logic [1:0] ZTAB_MEDIUM = 2'd1;
  localparam logic [1:0] ZTAB_FINE   = 2'd2;
  localparam logic [1:0] ZTAB_STEEP  = 2'd3;

  localparam logic [7:0] STICK_CENTRE = 8'h80;
  localparam logic [7:0] POS_RESET    = 8'h7f;

  typedef struct packed {
    logic [7:0] stick_x;
    logic [7:0] stick_y;
    logic       dir_up;
    logic       dir_down;
    logic       dir_left;
    logic       dir_right;
  } aspi_in_t;

  typedef struct packed {
    logic [7:0] position_first;
    logic [7:0] position_second;
  } aspi_out_t;

  typedef struct packed {
    logic [1:0] sensitivity;
    logic       axis_mode;
    logic       player_slot;
  } aspi_cfg_t;

  typedef struct packed {
    logic              hit;
    logic signed [3:0] delta;
  } aspi_zone_t;

  // Map a stick sample to a signed step; hit low inside the dead band.
  function automatic aspi_zone_t zone_lookup(input logic [7:0] v, input logic [1:0] sel);
    aspi_zone_t z;
    z = '{hit: 1'b0, delta: 4'sd0};
    if (v > STICK_CENTRE) begin
      case (sel)
        ZTAB_COARSE: begin
          if      (v >= 8'he0) z = '{hit: 1'b1, delta: 4'sd2};
          else if (v >= 8'ha0) z = '{hit: 1'b1, delta: 4'sd1};
        end
        ZTAB_MEDIUM: begin
          if      (v >= 8'hf0) z = '{hit: 1'b1, delta: 4'sd3};
          else if (v >= 8'hd0) z = '{hit: 1'b1, delta: 4'sd2};
          else if (v >= 8'ha0) z = '{hit: 1'b1, delta: 4'sd1};
        end
        ZTAB_FINE: begin
          if      (v >= 8'hf8) z = '{hit: 1'b1, delta: 4'sd4};
          else if (v >= 8'he8) z = '{hit: 1'b1, delta: 4'sd3};
          else if (v >= 8'hd0) z = '{hit: 1'b1, delta: 4'sd2};
          else if (v >= 8'h98) z = '{hit: 1'b1, delta: 4'sd1};
        end
        ZTAB_STEEP: begin
          if      (v >= 8'hf8) z = '{hit: 1'b1, delta: 4'sd5};
          else if (v >= 8'he8) z = '{hit: 1'b1, delta: 4'sd4};
          else if (v >= 8'hd8) z = '{hit: 1'b1, delta: 4'sd3};
          else if (v >= 8'hc0) z = '{hit: 1'b1, delta: 4'sd2};
          else if (v >= 8'h98) z = '{hit: 1'b1, delta: 4'sd1};
        end
        default: z = '{hit: 1'b0, delta: 4'sd0};
      endcase
    end else begin
      case (sel)
        ZTAB_COARSE: begin
          if      (v <= 8'h1f) z = '{hit: 1'b1, delta: -4'sd3};
          else if (v <= 8'h5f) z = '{hit: 1'b1, delta: -4'sd1};
        end
        ZTAB_MEDIUM: begin
          if      (v <= 8'h0f) z = '{hit: 1'b1, delta: -4'sd3};
          else if (v <= 8'h2f) z = '{hit: 1'b1, delta: -4'sd2};
          else if (v <= 8'h5f) z = '{hit: 1'b1, delta: -4'sd1};
        end
        ZTAB_FINE: begin
          if      (v <= 8'h07) z = '{hit: 1'b1, delta: -4'sd4};
          else if (v <= 8'h17) z = '{hit: 1'b1, delta: -4'sd3};
          else if (v <= 8'h2f) z = '{hit: 1'b1, delta: -4'sd2};
          else if (v <= 8'h67) z = '{hit: 1'b1, delta: -4'sd1};
        end
        ZTAB_STEEP: begin
          if      (v <= 8'h07) z = '{hit: 1'b1, delta: -4'sd5};
          else if (v <= 8'h17) z = '{hit: 1'b1, delta: -4'sd4};
          else if (v <= 8'h27) z = '{hit: 1'b1, delta: -4'sd3};
          else if (v <= 8'h3f) z = '{hit: 1'b1, delta: -4'sd2};
          else if (v <= 8'h67) z = '{hit: 1'b1, delta: -4'sd1};
        end
        default: z = '{hit: 1'b0, delta: 4'sd0};
      endcase
    end
    return z;
  endfunction

endpackage

### hdl/aspi_step.sv
module aspi_step (
  input  aspi_pkg::aspi_cfg_t cfg_i,
  input  aspi_pkg::aspi_in_t  item_i,
  input  aspi_pkg::aspi_out_t pos_i,
  output aspi_pkg::aspi_out_t pos_o
);
  import aspi_pkg::*;

  aspi_zone_t        zone_x;
  aspi_zone_t        zone_y;
  aspi_zone_t        zone_s;
  logic              analog_on;
  logic signed [3:0] delta_x;
  logic signed [3:0] delta_y;
  logic signed [3:0] delta_s;
  logic [7:0]        slot_pos;
  logic [9:0]        slot_sum;
  logic [7:0]        slot_sat;

  assign analog_on = (cfg_i.sensitivity != SENS_OFF);

  assign zone_x = zone_lookup(item_i.stick_x, cfg_i.sensitivity);
  assign zone_y = zone_lookup(item_i.stick_y, cfg_i.sensitivity);
  // Single-axis mode uses the next steeper table set
  assign zone_s = zone_lookup(item_i.stick_x, cfg_i.sensitivity + 2'd1);

  // Digital base delta; right and down take priority
  always_comb begin
    delta_x = 4'sd0;
    if (item_i.dir_left)  delta_x = -4'sd1;
    if (item_i.dir_right) delta_x = 4'sd1;
    if (analog_on && zone_x.hit) delta_x = zone_x.delta;

    delta_y = 4'sd0;
    if (item_i.dir_up)   delta_y = -4'sd1;
    if (item_i.dir_down) delta_y = 4'sd1;
    if (analog_on && zone_y.hit) delta_y = zone_y.delta;

    delta_s = (analog_on && zone_s.hit) ? zone_s.delta : 4'sd0;
  end

  assign slot_pos = cfg_i.player_slot ? pos_i.position_second : pos_i.position_first;
  assign slot_sum = {2'b00, slot_pos} + {{6{delta_s[3]}}, delta_s};

  // Clamp to 0..255: bit 9 flags underflow, bit 8 overflow
  always_comb begin
    if (slot_sum[9])      slot_sat = 8'h00;
    else if (slot_sum[8]) slot_sat = 8'hff;
    else                  slot_sat = slot_sum[7:0];
  end

  always_comb begin
    pos_o = pos_i;
    if (cfg_i.axis_mode == MODE_TWO_AXIS) begin
      pos_o.position_first  = pos_i.position_first  - {{4{delta_x[3]}}, delta_x};
      pos_o.position_second = pos_i.position_second - {{4{delta_y[3]}}, delta_y};
    end else if (cfg_i.player_slot) begin
      pos_o.position_second = slot_sat;
    end else begin
      pos_o.position_first = slot_sat;
    end
  end

endmodule

### hdl/analog_stick_position_integrator.sv
// Analog stick position integrator. Each input transfer carries one stick
// sample (x, y) and four direction flags, typically once per video frame, and
// produces exactly one output transfer holding both 8-bit position registers
// after the update. Both positions reset to 0x7f. In two-axis mode x steers the
// first register and y the second, wrapping modulo 256 with the step negated;
// in single-axis mode x alone steers the register picked by player_slot, with
// saturation to 0..255. The block takes a new transfer every cycle while its
// output is not stalled: the item sits in the input register while the step
// logic runs, then the result register presents it and raises output valid.
// Throughput is one item per cycle, set by the single step stage that reads and
// writes the position registers; a stalled output holds the step stage and then
// the input. Configuration writes through cfg_we_i/cfg_idx_i/cfg_wdata_i take
// effect at once; write them only while no item is in flight. Index 3 is
// ignored.
module analog_stick_position_integrator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [aspi_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [aspi_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  aspi_pkg::aspi_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output aspi_pkg::aspi_out_t                 out_data_o
);
  import aspi_pkg::*;

  aspi_cfg_t cfg_q;
  logic      s1_valid_q;
  aspi_in_t  s1_item_q;
  aspi_out_t pos_q;
  aspi_out_t pos_d;
  logic      out_valid_q;
  aspi_out_t out_q;
  logic      s1_adv;

  // Step stage may move on whenever the result register is free or draining
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SENSITIVITY: cfg_q.sensitivity <= cfg_wdata_i;
        CFG_AXIS_MODE:   cfg_q.axis_mode   <= cfg_wdata_i[0];
        CFG_PLAYER_SLOT: cfg_q.player_slot <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register: hold the item until the step stage advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
  end

  aspi_step u_step (
    .cfg_i  (cfg_q),
    .item_i (s1_item_q),
    .pos_i  (pos_q),
    .pos_o  (pos_d)
  );

  // Position state and result register advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '{position_first: POS_RESET, position_second: POS_RESET};
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q <= pos_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "analog_stick_position_integrator_macros.svh"

  `ASPI_ASSERT(a_ready_when_empty, !out_valid_q, in_ready_o, "input stalled with empty output")
  `ASPI_ASSERT(a_out_matches_state, out_valid_q, out_q == pos_q, "result differs from state")
  `ASPI_ASSERT_NEXT(a_pos_hold_on_stall, !s1_adv, $stable(pos_q), "positions moved while stalled")
  `ASPI_ASSERT_NEXT(a_single_keeps_second, s1_adv && cfg_q.axis_mode && !cfg_q.player_slot, pos_q.position_second == $past(pos_q.position_second), "unselected slot changed")
  `ASPI_ASSERT_NEXT(a_single_keeps_first, s1_adv && cfg_q.axis_mode && cfg_q.player_slot, pos_q.position_first == $past(pos_q.position_first), "unselected slot changed")

endmodule
